[design/double_hash_multiset_table_macros.svh]
`ifndef DOUBLE_HASH_MULTISET_TABLE_MACROS_SVH
`define DOUBLE_HASH_MULTISET_TABLE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define DHMT_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define DHMT_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/dhmt_pkg.sv]
package dhmt_pkg;

    localparam int OP_W      = 2;
    localparam int KEY_W     = 32;
    localparam int STAT_W    = 2;
    localparam int CNT_OUT_W = 11;
    localparam int OUT_W     = 24;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_COUNT  = 2'd2;

    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd0;
    localparam logic [STAT_W-1:0] ST_USED  = 2'd1;
    localparam logic [STAT_W-1:0] ST_GONE  = 2'd2;

    localparam logic [KEY_W-1:0] STEP_OFFSET = 32'd79;

    typedef struct packed {
        logic              rd_en;
        logic              key_we;
        logic              stat_we;
        logic [STAT_W-1:0] stat_wdata;
    } mem_ctl_t;

endpackage

[design/dhmt_slot_mem.sv]
module dhmt_slot_mem
    import dhmt_pkg::*;
#(
    parameter int DEPTH = 1024
)
(
    input  logic                     clk,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  mem_ctl_t                 ctl,
    input  logic [KEY_W-1:0]         key_wdata,
    output logic [KEY_W-1:0]         key_rdata,
    output logic [STAT_W-1:0]        stat_rdata
);

    logic [KEY_W-1:0]  key_mem [DEPTH];
    logic [STAT_W-1:0] stat_mem [DEPTH];
    logic [KEY_W-1:0]  key_rd_reg;
    logic [STAT_W-1:0] stat_rd_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.key_we)
        begin
            key_mem[addr] <= key_wdata;
        end
        if (ctl.rd_en)
        begin
            key_rd_reg <= key_mem[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.stat_we)
        begin
            stat_mem[addr] <= ctl.stat_wdata;
        end
        if (ctl.rd_en)
        begin
            stat_rd_reg <= stat_mem[addr];
        end
    end

    assign key_rdata  = key_rd_reg;
    assign stat_rdata = stat_rd_reg;

endmodule

[design/double_hash_multiset_table.sv]
// Multiset of 32-bit keys in an open-addressed table with double hashing.
// Input channel s_*: s_tuser carries the operation (insert, remove one copy,
// count), s_tdata carries the key. Output channel m_*: one result item per
// input item, with success, occurrences, element count and table-full flag.
// After reset the block sweeps the slot status memory and holds s_tready
// low until the sweep is done.
// An item is taken in the idle state. Each probe is then a registered read
// of the single-port slot memory followed by a compare of the slot that,
// if needed, writes it back and steps the address. The output register is
// loaded last. A full-table insert or an unused operation skips the probes
// and goes straight to loading the output register.
// The output register holds a result until m_tready takes it. The block
// accepts the next item while a result waits, and finishes that item only
// once the output register is free.
`include "double_hash_multiset_table_macros.svh"

module double_hash_multiset_table
    import dhmt_pkg::*;
#(
    parameter int CAPACITY = 1024
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [KEY_W-1:0] s_tdata,  // [31:0] key
    input  logic [OP_W-1:0]  s_tuser,  // [1:0] operation
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata   // success, occurrences, element_count, table_full
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_PROBE = 3'd2;
    localparam logic [2:0] S_EVAL  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [AW-1:0]    addr_reg, addr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0] m_tdata_reg, m_tdata_next;
    logic [AW-1:0]    probe_reg, probe_next;
    logic [AW-1:0]    h2_reg, h2_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [OP_W-1:0]  op_reg, op_next;
    logic [CW-1:0]    occ_reg, occ_next;
    logic             success_reg, success_next;
    logic             full_reg, full_next;

    mem_ctl_t          mem_ctl;
    logic [KEY_W-1:0]  key_rdata;
    logic [STAT_W-1:0] stat_rdata;
    logic [KEY_W-1:0]  step_sum;
    logic              accept;
    logic              out_free;
    logic              last_probe;
    logic              key_hit;
    logic              remove_hit;
    logic              res_success;

    dhmt_slot_mem #(
        .DEPTH(CAPACITY)
    ) u_slot_mem (
        .clk       (clk),
        .addr      (addr_reg),
        .ctl       (mem_ctl),
        .key_wdata (key_reg),
        .key_rdata (key_rdata),
        .stat_rdata(stat_rdata)
    );

    assign s_tready    = (state_reg == S_IDLE);
    assign accept      = s_tvalid && s_tready;
    assign out_free    = !m_tvalid_reg || m_tready;
    assign step_sum    = {s_tdata[KEY_W-2:0], 1'b0} + STEP_OFFSET;
    assign last_probe  = (probe_reg == {AW{1'b1}});
    assign key_hit     = (stat_rdata == ST_USED) && (key_rdata == key_reg);
    assign remove_hit  = (state_reg == S_EVAL) && (op_reg == OP_REMOVE) && key_hit;
    assign res_success = (op_reg == OP_COUNT) ? (occ_reg != '0) : success_reg;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb
    begin
        state_next         = state_reg;
        addr_next          = addr_reg;
        count_next         = count_reg;
        m_tvalid_next      = m_tvalid_reg;
        m_tdata_next       = m_tdata_reg;
        probe_next         = probe_reg;
        h2_next            = h2_reg;
        key_next           = key_reg;
        op_next            = op_reg;
        occ_next           = occ_reg;
        success_next       = success_reg;
        full_next          = full_reg;
        mem_ctl.rd_en      = 1'b0;
        mem_ctl.key_we     = 1'b0;
        mem_ctl.stat_we    = 1'b0;
        mem_ctl.stat_wdata = ST_EMPTY;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_ctl.stat_we = 1'b1;
                addr_next       = addr_reg + 1'b1;
                if (addr_reg == {AW{1'b1}})
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    key_next     = s_tdata;
                    op_next      = s_tuser;
                    addr_next    = s_tdata[AW-1:0];
                    h2_next      = step_sum[AW-1:0];
                    probe_next   = '0;
                    occ_next     = '0;
                    success_next = 1'b0;
                    full_next    = 1'b0;
                    case (s_tuser) inside
                        OP_INSERT:
                        begin
                            if (count_reg == CW'(CAPACITY))
                            begin
                                full_next  = 1'b1;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_PROBE;
                            end
                        end
                        OP_REMOVE, OP_COUNT:
                        begin
                            state_next = S_PROBE;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_PROBE:
            begin
                mem_ctl.rd_en = 1'b1;
                state_next    = S_EVAL;
            end
            S_EVAL:
            begin
                addr_next  = addr_reg + h2_reg;
                probe_next = probe_reg + 1'b1;
                state_next = last_probe ? S_DONE : S_PROBE;
                if (op_reg == OP_INSERT)
                begin
                    if (stat_rdata != ST_USED)
                    begin
                        mem_ctl.key_we     = 1'b1;
                        mem_ctl.stat_we    = 1'b1;
                        mem_ctl.stat_wdata = ST_USED;
                        count_next         = count_reg + 1'b1;
                        success_next       = 1'b1;
                        addr_next          = addr_reg;
                        state_next         = S_DONE;
                    end
                    else if (last_probe)
                    begin
                        full_next = 1'b1;
                    end
                end
                else if (stat_rdata == ST_EMPTY)
                begin
                    addr_next  = addr_reg;
                    state_next = S_DONE;
                end
                else if (op_reg == OP_REMOVE)
                begin
                    if (key_hit)
                    begin
                        mem_ctl.stat_we    = 1'b1;
                        mem_ctl.stat_wdata = ST_GONE;
                        if (count_reg != '0)
                        begin
                            count_next = count_reg - 1'b1;
                        end
                        success_next = 1'b1;
                        addr_next    = addr_reg;
                        state_next   = S_DONE;
                    end
                end
                else if (key_hit)
                begin
                    occ_next = occ_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {full_reg, CNT_OUT_W'(count_reg),
                                     CNT_OUT_W'(occ_reg), res_success};
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            addr_reg     <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            addr_reg     <= addr_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        probe_reg   <= probe_next;
        h2_reg      <= h2_next;
        key_reg     <= key_next;
        op_reg      <= op_next;
        occ_reg     <= occ_next;
        success_reg <= success_next;
        full_reg    <= full_next;
    end

    `DHMT_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CW'(CAPACITY),
                     "Element count above capacity.")
    `DHMT_ASSERT_IMP(a_full_no_success, m_tvalid, !(m_tdata[0] && m_tdata[OUT_W-1]),
                     "Result is both stored and full.")
    `DHMT_ASSERT_NXT(a_remove_dec, remove_hit && (count_reg != '0),
                     count_reg == $past(count_reg) - 1'b1,
                     "Remove did not lower the count.")
    `DHMT_ASSERT_IMP(a_write_state, mem_ctl.stat_we,
                     (state_reg == S_CLEAR) || (state_reg == S_EVAL),
                     "Status write outside sweep or compare.")

endmodule
